// ===== hw/rtl/prf_pkg.sv =====
// Package: sizes, command and status codes, and shared types of the packet ring FIFO.
`default_nettype none
package prf_pkg;
	localparam int FIFO_DEPTH = 8;
	localparam int MAX_LEN    = 64;
	localparam int STORE_SIZE = FIFO_DEPTH * MAX_LEN;
	localparam int SLOT_W     = $clog2(FIFO_DEPTH);
	localparam int OFS_W      = $clog2(MAX_LEN + 1);
	localparam int ADDR_W     = $clog2(STORE_SIZE);
	localparam int LEN_W      = 7;

	typedef enum logic [1:0] {
		CMD_APPEND       = 2'd0,
		CMD_APPEND_CLOSE = 2'd1,
		CMD_CLOSE        = 2'd2,
		CMD_READ         = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_DROPPED   = 2'd2,
		ST_TRUNCATED = 2'd3
	} status_t;

	typedef struct packed {
		logic              we;
		logic              re;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        wdata;
	} ram_req_t;

	typedef struct packed {
		logic             byte_valid;
		logic             packet_last;
		logic [LEN_W-1:0] packet_length;
		status_t          status;
		logic             not_empty;
	} result_t;
endpackage
`default_nettype wire

// ===== hw/rtl/prf_if.sv =====
// Interfaces: command beat channel and result beat channel.
`default_nettype none
interface prf_cmd_if;
	logic          valid;
	logic          ready;
	prf_pkg::cmd_t cmd;
	logic [7:0]    data_byte;

	modport source (output valid, cmd, data_byte, input ready);
	modport sink (input valid, cmd, data_byte, output ready);
endinterface

interface prf_rsp_if;
	logic                      valid;
	logic                      ready;
	logic [7:0]                read_byte;
	logic                      byte_valid;
	logic                      packet_last;
	logic [prf_pkg::LEN_W-1:0] packet_length;
	prf_pkg::status_t          status;
	logic                      not_empty;

	modport source (output valid, read_byte, byte_valid, packet_last, packet_length, status,
		not_empty, input ready);
	modport sink (input valid, read_byte, byte_valid, packet_last, packet_length, status,
		not_empty, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/prf_byte_ram.sv =====
// Single-port packet byte buffer with registered read data.
`default_nettype none
module prf_byte_ram (
	input  wire logic              clk,
	input  wire prf_pkg::ram_req_t req,
	output logic [7:0]             rd_data
);
	logic [7:0] mem [prf_pkg::STORE_SIZE];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.re) begin
			rd_data <= mem[req.addr];
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/prf_ring_ctrl.sv =====
// Ring control: slot and offset pointers, packet length table, buffer requests.
`default_nettype none
module prf_ring_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                accept,
	input  wire prf_pkg::cmd_t       cmd,
	input  wire logic [7:0]          data_byte,
	output prf_pkg::ram_req_t        ram_req,
	output prf_pkg::result_t         result
);
	logic [prf_pkg::SLOT_W-1:0] write_slot_q, read_slot_q;
	logic [prf_pkg::SLOT_W-1:0] write_slot_d, read_slot_d;
	logic [prf_pkg::OFS_W-1:0]  write_offset_q, read_offset_q;
	logic [prf_pkg::OFS_W-1:0]  write_offset_d, read_offset_d;
	logic [prf_pkg::OFS_W-1:0]  lengths_q [prf_pkg::FIFO_DEPTH];
	logic [prf_pkg::OFS_W-1:0]  new_len, rd_len;
	logic [prf_pkg::SLOT_W-1:0] wr_next, rd_next;
	logic                       append, close, trunc, drop, len_we;
	logic                       rd_last, rd_byte;
	logic [prf_pkg::ADDR_W-1:0] wr_addr, rd_addr;

	function automatic logic [prf_pkg::SLOT_W-1:0] slot_after(
		input logic [prf_pkg::SLOT_W-1:0] s);
		logic [prf_pkg::SLOT_W-1:0] r;
		if (s == prf_pkg::SLOT_W'(prf_pkg::FIFO_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = s + prf_pkg::SLOT_W'(1);
		end
		return r;
	endfunction

	assign wr_next = slot_after(write_slot_q);
	assign rd_next = slot_after(read_slot_q);
	assign rd_len  = lengths_q[read_slot_q];
	assign wr_addr = prf_pkg::ADDR_W'(write_slot_q) * prf_pkg::ADDR_W'(prf_pkg::MAX_LEN)
		+ prf_pkg::ADDR_W'(write_offset_q);
	assign rd_addr = prf_pkg::ADDR_W'(read_slot_q) * prf_pkg::ADDR_W'(prf_pkg::MAX_LEN)
		+ prf_pkg::ADDR_W'(read_offset_q);

	always_comb begin
		append         = (cmd == prf_pkg::CMD_APPEND) || (cmd == prf_pkg::CMD_APPEND_CLOSE);
		close          = (cmd == prf_pkg::CMD_APPEND_CLOSE) || (cmd == prf_pkg::CMD_CLOSE);
		trunc          = 1'b0;
		drop           = 1'b0;
		len_we         = 1'b0;
		rd_last        = 1'b0;
		rd_byte        = 1'b0;
		new_len        = write_offset_q;
		write_slot_d   = write_slot_q;
		read_slot_d    = read_slot_q;
		write_offset_d = write_offset_q;
		read_offset_d  = read_offset_q;
		ram_req        = '{we: 1'b0, re: 1'b0, addr: wr_addr, wdata: data_byte};
		result         = '{byte_valid: 1'b0, packet_last: 1'b0, packet_length: '0,
			status: prf_pkg::ST_OK, not_empty: 1'b0};

		if (cmd == prf_pkg::CMD_READ) begin
			ram_req.addr = rd_addr;
			if (read_slot_q == write_slot_q) begin
				result.status = prf_pkg::ST_EMPTY;
			end else begin
				result.packet_length = prf_pkg::LEN_W'(rd_len);
				if (read_offset_q >= rd_len) begin
					rd_last = 1'b1;
				end else begin
					rd_byte       = 1'b1;
					read_offset_d = read_offset_q + prf_pkg::OFS_W'(1);
					rd_last       = (read_offset_q + prf_pkg::OFS_W'(1)) >= rd_len;
				end
				if (rd_last) begin
					read_slot_d   = rd_next;
					read_offset_d = '0;
				end
			end
			ram_req.re         = accept && rd_byte;
			result.byte_valid  = rd_byte;
			result.packet_last = rd_last;
		end else begin
			if (append) begin
				if (write_offset_q >= prf_pkg::OFS_W'(prf_pkg::MAX_LEN)) begin
					trunc   = 1'b1;
					new_len = prf_pkg::OFS_W'(prf_pkg::MAX_LEN);
				end else begin
					new_len = write_offset_q + prf_pkg::OFS_W'(1);
				end
				ram_req.we     = accept && !trunc;
				write_offset_d = new_len;
			end
			if (close) begin
				len_we = accept;
				if (wr_next == read_slot_q) begin
					drop          = 1'b1;
					read_slot_d   = rd_next;
					read_offset_d = '0;
				end
				write_slot_d   = wr_next;
				write_offset_d = '0;
			end
			if (drop) begin
				result.status = prf_pkg::ST_DROPPED;
			end else if (trunc) begin
				result.status = prf_pkg::ST_TRUNCATED;
			end
		end
		result.not_empty = read_slot_d != write_slot_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_slot_q   <= '0;
			read_slot_q    <= '0;
			write_offset_q <= '0;
			read_offset_q  <= '0;
		end else if (accept) begin
			write_slot_q   <= write_slot_d;
			read_slot_q    <= read_slot_d;
			write_offset_q <= write_offset_d;
			read_offset_q  <= read_offset_d;
		end
	end

	always_ff @(posedge clk) begin
		if (len_we) begin
			lengths_q[write_slot_q] <= new_len;
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/packet_ring_fifo_drop_oldest.sv =====
// Top level: packet ring FIFO with drop-oldest overflow.
// A ring of FIFO_DEPTH packet slots (one kept empty) of up to MAX_LEN bytes each. Every command
// beat yields exactly one result beat, valid in the cycle after acceptance; a new command is taken
// in the same cycle the previous result is taken, so the block sustains one beat per cycle while
// rsp.ready stays high. All pointer and length updates complete in the accepting cycle; the byte
// of a read comes from the single-port byte buffer, whose registered read data aligns with the
// result register. Bytes past MAX_LEN are dropped (status truncated); a commit into a full ring
// discards the oldest packet (status dropped). Buffer contents are not cleared at reset.
`default_nettype none
module packet_ring_fifo_drop_oldest (
	input  wire logic  clk,
	input  wire logic  arst_n,
	prf_cmd_if.sink    req,
	prf_rsp_if.source  rsp
);
	prf_pkg::ram_req_t ram_req;
	prf_pkg::result_t  result, result_q;
	logic [7:0]        rd_data;
	logic              accept, rsp_valid_q;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	prf_ring_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.cmd       (req.cmd),
		.data_byte (req.data_byte),
		.ram_req   (ram_req),
		.result    (result)
	);

	prf_byte_ram u_ram (
		.clk     (clk),
		.req     (ram_req),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (req.ready) begin
			rsp_valid_q <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= result;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.read_byte     = result_q.byte_valid ? rd_data : 8'd0;
	assign rsp.byte_valid    = result_q.byte_valid;
	assign rsp.packet_last   = result_q.packet_last;
	assign rsp.packet_length = result_q.packet_length;
	assign rsp.status        = result_q.status;
	assign rsp.not_empty     = result_q.not_empty;
endmodule
`default_nettype wire
